// File: design/falling_sand_grid_step_assert.svh
// assertion macros for the falling sand grid step checker
`ifndef FALLING_SAND_GRID_STEP_ASSERT_SVH
`define FALLING_SAND_GRID_STEP_ASSERT_SVH

// same-cycle implication
`define FSG_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/fsg_pkg.sv
// shared types, constants and codes for the falling sand grid step
`default_nettype none

package fsg_pkg;

  localparam int GRID_SIDE     = 128;
  localparam int MAX_PARTICLES = 1024;

  localparam int COORD_W = 7;
  localparam int IDX_W   = 10;
  localparam int GA_W    = $clog2(GRID_SIDE);
  localparam int PA_W    = $clog2(MAX_PARTICLES);
  localparam int CNT_W   = $clog2(MAX_PARTICLES + 1);
  localparam int OP_W    = 2;
  localparam int ST_W    = 2;

  localparam int IN_W    = 2 * COORD_W + IDX_W;
  localparam int OUT_USE = 2 * COORD_W + 1 + 2 * CNT_W;
  localparam int OUT_W   = ((OUT_USE + 7) / 8) * 8;
  localparam int OUT_PAD = OUT_W - OUT_USE;

  localparam logic EMPTY  = 1'b0;
  localparam logic FILLED = 1'b1;

  localparam logic [OP_W-1:0] OP_PLACE  = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ_P = 2'd2;
  localparam logic [OP_W-1:0] OP_READ_C = 2'd3;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_OCCUPIED = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE    = 2'd3;

  typedef logic [COORD_W-1:0]   coord_t;
  typedef logic [GRID_SIDE-1:0] row_t;
  typedef logic [GA_W-1:0]      gaddr_t;
  typedef logic [PA_W-1:0]      paddr_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef struct packed {
    logic   re;
    gaddr_t raddr;
    logic   we;
    gaddr_t waddr;
    row_t   wdata;
  } grid_req_t;

  typedef struct packed {
    coord_t col;
    coord_t row;
  } ppos_t;

  typedef struct packed {
    logic   re;
    paddr_t raddr;
    logic   we;
    paddr_t waddr;
    ppos_t  wdata;
  } plist_req_t;

  typedef struct packed {
    logic   found;
    coord_t col;
  } move_t;

endpackage

`default_nettype wire

// File: design/falling_sand_grid_step.sv
// top level of the falling sand grid step: sequencer, result register and memories
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-----------------------------------------------
//  s_*     | in  | s_tvalid / s_tready  | tuser opcode; tdata cell_x, cell_y, index
//  m_*     | out | m_tvalid / m_tready  | tuser status; tdata pos, occupied, counts
//
//  place, read particle and read cell each read one memory word first; a tick
//  reads each particle, the row below, then writes that row and clears the old
//  cell; a stuck particle skips the writes, one on the bottom row also the read
//  after reset the grid is swept one row a cycle, all 128 rows, with s_tready low
//  s_tready is high only while the sequencer is idle; one result waits in the
//  output register and a finished item holds until that register is free
`default_nettype none

module falling_sand_grid_step (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // cell_x, cell_y, particle_index
  input  wire logic [fsg_pkg::IN_W-1:0]    s_tdata,
  // opcode
  input  wire logic [fsg_pkg::OP_W-1:0]    s_tuser,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // pos_x, pos_y, occupied, moved_count, particle_total, zero fill
  output logic [fsg_pkg::OUT_W-1:0]        m_tdata,
  // status
  output logic [fsg_pkg::ST_W-1:0]         m_tuser
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PL_CHK   = 4'd1;
  localparam logic [3:0] S_RP_OUT   = 4'd2;
  localparam logic [3:0] S_RC_OUT   = 4'd3;
  localparam logic [3:0] S_TK_NEXT  = 4'd4;
  localparam logic [3:0] S_TK_POS   = 4'd5;
  localparam logic [3:0] S_TK_BELOW = 4'd6;
  localparam logic [3:0] S_TK_ABOVE = 4'd7;
  localparam logic [3:0] S_FIN      = 4'd8;

  logic [3:0] state, state_next;

  fsg_pkg::cnt_t   count, count_next;
  fsg_pkg::cnt_t   idx, idx_next;
  fsg_pkg::cnt_t   moved, moved_next;
  fsg_pkg::coord_t col, col_next;
  fsg_pkg::coord_t row, row_next;
  fsg_pkg::coord_t px, px_next;
  fsg_pkg::coord_t py, py_next;
  logic            occ, occ_next;
  logic [fsg_pkg::ST_W-1:0] status, status_next;

  logic [fsg_pkg::OP_W-1:0] in_op;
  fsg_pkg::coord_t          in_x;
  fsg_pkg::coord_t          in_y;
  logic [fsg_pkg::IDX_W-1:0] in_idx;
  logic                     in_grid;
  logic                     accept;
  logic [fsg_pkg::COORD_W:0] row_inc;
  logic                     load_out;

  fsg_pkg::grid_req_t  greq;
  fsg_pkg::row_t       grdata;
  logic                clearing;
  fsg_pkg::plist_req_t preq;
  fsg_pkg::ppos_t      prdata;

  logic            use_choice;
  fsg_pkg::coord_t mod_col;
  logic            mod_val;
  logic            test_bit;
  fsg_pkg::move_t  choice;
  fsg_pkg::row_t   mod_word;

  fsg_grid u_grid (
    .clk      (clk),
    .rst      (rst),
    .req      (greq),
    .rdata    (grdata),
    .clearing (clearing)
  );

  fsg_plist u_plist (
    .clk   (clk),
    .req   (preq),
    .rdata (prdata)
  );

  fsg_move_unit u_move (
    .word       (grdata),
    .test_col   (col),
    .use_choice (use_choice),
    .mod_col    (mod_col),
    .mod_val    (mod_val),
    .test_bit   (test_bit),
    .choice     (choice),
    .mod_word   (mod_word)
  );

  assign in_op    = s_tuser;
  assign in_x     = s_tdata[fsg_pkg::COORD_W-1:0];
  assign in_y     = s_tdata[2*fsg_pkg::COORD_W-1:fsg_pkg::COORD_W];
  assign in_idx   = s_tdata[fsg_pkg::IN_W-1:2*fsg_pkg::COORD_W];
  assign in_grid  = ({1'b0, in_x} < (fsg_pkg::COORD_W+1)'(fsg_pkg::GRID_SIDE)) &&
                    ({1'b0, in_y} < (fsg_pkg::COORD_W+1)'(fsg_pkg::GRID_SIDE));
  assign s_tready = (state == S_IDLE) && !clearing;
  assign accept   = s_tvalid && s_tready;
  assign row_inc  = {1'b0, prdata.row} + 1'b1;
  assign load_out = (state == S_FIN) && (!m_tvalid || m_tready);

  always_comb begin
    state_next  = state;
    count_next  = count;
    idx_next    = idx;
    moved_next  = moved;
    col_next    = col;
    row_next    = row;
    px_next     = px;
    py_next     = py;
    occ_next    = occ;
    status_next = status;
    greq        = '0;
    preq        = '0;
    use_choice  = 1'b0;
    mod_col     = col;
    mod_val     = fsg_pkg::FILLED;

    case (state)
      S_IDLE: begin
        if (accept) begin
          col_next    = in_x;
          row_next    = in_y;
          px_next     = '0;
          py_next     = '0;
          occ_next    = 1'b0;
          moved_next  = '0;
          idx_next    = '0;
          status_next = fsg_pkg::ST_OK;
          case (in_op)
            fsg_pkg::OP_PLACE, fsg_pkg::OP_READ_C: begin
              if (!in_grid) begin
                status_next = fsg_pkg::ST_RANGE;
                state_next  = S_FIN;
              end else begin
                greq.re    = 1'b1;
                greq.raddr = in_y[fsg_pkg::GA_W-1:0];
                state_next = (in_op == fsg_pkg::OP_PLACE) ? S_PL_CHK : S_RC_OUT;
              end
            end
            fsg_pkg::OP_TICK: begin
              state_next = S_TK_NEXT;
            end
            fsg_pkg::OP_READ_P: begin
              if (fsg_pkg::cnt_t'(in_idx) >= count) begin
                status_next = fsg_pkg::ST_RANGE;
                state_next  = S_FIN;
              end else begin
                preq.re    = 1'b1;
                preq.raddr = in_idx[fsg_pkg::PA_W-1:0];
                state_next = S_RP_OUT;
              end
            end
            default: begin
              state_next = S_FIN;
            end
          endcase
        end
      end
      S_PL_CHK: begin
        if (test_bit == fsg_pkg::FILLED) begin
          status_next = fsg_pkg::ST_OCCUPIED;
        end else if (count >= fsg_pkg::cnt_t'(fsg_pkg::MAX_PARTICLES)) begin
          status_next = fsg_pkg::ST_FULL;
        end else begin
          greq.we        = 1'b1;
          greq.waddr     = row[fsg_pkg::GA_W-1:0];
          greq.wdata     = mod_word;
          preq.we        = 1'b1;
          preq.waddr     = count[fsg_pkg::PA_W-1:0];
          preq.wdata.col = col;
          preq.wdata.row = row;
          count_next     = count + 1'b1;
        end
        state_next = S_FIN;
      end
      S_RC_OUT: begin
        occ_next   = test_bit;
        state_next = S_FIN;
      end
      S_RP_OUT: begin
        px_next    = prdata.col;
        py_next    = prdata.row;
        state_next = S_FIN;
      end
      S_TK_NEXT: begin
        if (idx >= count) begin
          state_next = S_FIN;
        end else begin
          preq.re    = 1'b1;
          preq.raddr = idx[fsg_pkg::PA_W-1:0];
          state_next = S_TK_POS;
        end
      end
      S_TK_POS: begin
        col_next = prdata.col;
        row_next = prdata.row;
        if (row_inc >= (fsg_pkg::COORD_W+1)'(fsg_pkg::GRID_SIDE)) begin
          // bottom row, stays put
          idx_next   = idx + 1'b1;
          state_next = S_TK_NEXT;
        end else begin
          greq.re    = 1'b1;
          greq.raddr = row_inc[fsg_pkg::GA_W-1:0];
          state_next = S_TK_BELOW;
        end
      end
      S_TK_BELOW: begin
        use_choice = 1'b1;
        if (!choice.found) begin
          idx_next   = idx + 1'b1;
          state_next = S_TK_NEXT;
        end else begin
          greq.we        = 1'b1;
          greq.waddr     = row[fsg_pkg::GA_W-1:0] + 1'b1;
          greq.wdata     = mod_word;
          greq.re        = 1'b1;
          greq.raddr     = row[fsg_pkg::GA_W-1:0];
          preq.we        = 1'b1;
          preq.waddr     = idx[fsg_pkg::PA_W-1:0];
          preq.wdata.col = choice.col;
          preq.wdata.row = row + 1'b1;
          moved_next     = moved + 1'b1;
          state_next     = S_TK_ABOVE;
        end
      end
      S_TK_ABOVE: begin
        mod_col    = col;
        mod_val    = fsg_pkg::EMPTY;
        greq.we    = 1'b1;
        greq.waddr = row[fsg_pkg::GA_W-1:0];
        greq.wdata = mod_word;
        idx_next   = idx + 1'b1;
        state_next = S_TK_NEXT;
      end
      S_FIN: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    moved  <= moved_next;
    col    <= col_next;
    row    <= row_next;
    px     <= px_next;
    py     <= py_next;
    occ    <= occ_next;
    status <= status_next;
    if (load_out) begin
      m_tdata <= {{fsg_pkg::OUT_PAD{1'b0}}, count, moved, occ, py, px};
      m_tuser <= status;
    end
  end

endmodule

`default_nettype wire

// File: design/fsg_grid.sv
// occupancy grid memory, one row per word, with clearing sweep after reset
`default_nettype none

module fsg_grid (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fsg_pkg::grid_req_t req,
  output fsg_pkg::row_t          rdata,
  output logic                   clearing
);

  fsg_pkg::row_t   mem [fsg_pkg::GRID_SIDE];
  fsg_pkg::gaddr_t clr_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      if (clr_row == fsg_pkg::gaddr_t'(fsg_pkg::GRID_SIDE - 1)) begin
        clearing <= 1'b0;
      end
      clr_row <= clr_row + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_row] <= '0;
    end else if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/fsg_plist.sv
// particle position list memory in creation order
`default_nettype none

module fsg_plist (
  input  wire logic               clk,
  input  wire fsg_pkg::plist_req_t req,
  output fsg_pkg::ppos_t          rdata
);

  fsg_pkg::ppos_t mem [fsg_pkg::MAX_PARTICLES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/fsg_move_unit.sv
// shared cell unit: bit test, fall target choice and row bit update
`default_nettype none

module fsg_move_unit (
  input  wire fsg_pkg::row_t   word,
  input  wire fsg_pkg::coord_t test_col,
  input  wire logic            use_choice,
  input  wire fsg_pkg::coord_t mod_col,
  input  wire logic            mod_val,
  output logic                 test_bit,
  output fsg_pkg::move_t       choice,
  output fsg_pkg::row_t        mod_word
);

  fsg_pkg::gaddr_t c;
  fsg_pkg::gaddr_t cr;
  fsg_pkg::gaddr_t cl;
  fsg_pkg::gaddr_t mc;
  logic            right_ok;
  logic            left_ok;

  always_comb begin
    c        = test_col[fsg_pkg::GA_W-1:0];
    cr       = c + 1'b1;
    cl       = c - 1'b1;
    test_bit = word[c];
    right_ok = (c != fsg_pkg::gaddr_t'(fsg_pkg::GRID_SIDE - 1)) && (word[cr] == fsg_pkg::EMPTY);
    left_ok  = (c != '0) && (word[cl] == fsg_pkg::EMPTY);

    if (word[c] == fsg_pkg::EMPTY) begin
      choice.found = 1'b1;
      choice.col   = test_col;
    end else if (right_ok) begin
      choice.found = 1'b1;
      choice.col   = test_col + 1'b1;
    end else if (left_ok) begin
      choice.found = 1'b1;
      choice.col   = test_col - 1'b1;
    end else begin
      choice.found = 1'b0;
      choice.col   = test_col;
    end

    mc           = use_choice ? choice.col[fsg_pkg::GA_W-1:0] : mod_col[fsg_pkg::GA_W-1:0];
    mod_word     = word;
    mod_word[mc] = mod_val;
  end

endmodule

`default_nettype wire

// File: design/fsg_checker.sv
// port checker for the falling sand grid step, bound to the top level
`default_nettype none

`include "falling_sand_grid_step_assert.svh"

module fsg_checker (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     s_tvalid,
  input wire logic                     s_tready,
  input wire logic                     m_tvalid,
  input wire logic                     m_tready,
  input wire logic [fsg_pkg::OUT_W-1:0] m_tdata,
  input wire logic [fsg_pkg::ST_W-1:0]  m_tuser
);

  localparam int MV_LO = 2 * fsg_pkg::COORD_W + 1;
  localparam int TT_LO = MV_LO + fsg_pkg::CNT_W;

  fsg_pkg::cnt_t moved;
  fsg_pkg::cnt_t total;
  logic          occ;

  assign moved = m_tdata[MV_LO + fsg_pkg::CNT_W - 1:MV_LO];
  assign total = m_tdata[TT_LO + fsg_pkg::CNT_W - 1:TT_LO];
  assign occ   = m_tdata[2*fsg_pkg::COORD_W];

  `FSG_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  `FSG_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "input taken twice in a row")
  `FSG_ASSERT_IMPLY(a_total_bound, clk, rst, m_tvalid, total <= fsg_pkg::cnt_t'(fsg_pkg::MAX_PARTICLES), "particle total above capacity")
  `FSG_ASSERT_IMPLY(a_moved_bound, clk, rst, m_tvalid, moved <= total, "moved count above particle total")
  `FSG_ASSERT_IMPLY(a_err_clean, clk, rst, m_tvalid && (m_tuser != fsg_pkg::ST_OK), (moved == '0) && !occ, "refused transaction carries data")

endmodule

bind falling_sand_grid_step fsg_checker u_fsg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
